/* src/pcxrle_pkg.sv */
// ----------------------------------------------------------------------------
// pcxrle_pkg
// Types and constants shared by the 8-bit PCX run-length decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcxrle_pkg;

    localparam logic [7:0] RUN_MARK     = 8'hC0;
    localparam int         COUNT_W      = 6;
    localparam int         COL_W        = 10;
    localparam int         ROW_W        = 9;
    localparam int         CFG_W        = 10;

    localparam logic [COL_W-1:0] MAX_WIDTH     = 10'd640;
    localparam logic [ROW_W-1:0] MAX_HEIGHT    = 9'd480;
    localparam logic [COL_W-1:0] RESET_WIDTH   = 10'd320;
    localparam logic [ROW_W-1:0] RESET_HEIGHT  = 9'd200;

    // Configuration register indexes.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // One run of pixels, already clipped to the row end.
    typedef struct packed {
        logic [7:0]         value;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [COUNT_W-1:0] count;
        logic               img_end;
    } t_cmd;

endpackage

`default_nettype wire

/* src/pcxrle_front.sv */
// ----------------------------------------------------------------------------
// pcxrle_front
// Takes code bytes, tracks the run header, column and row, and turns each
// byte into at most one clipped run command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcxrle_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [7:0]                    i_code_byte,
    input  wire logic [pcxrle_pkg::COL_W-1:0]  i_width,
    input  wire logic [pcxrle_pkg::ROW_W-1:0]  i_height,
    output logic                               o_cmd_push,
    output pcxrle_pkg::t_cmd                   o_cmd
);
    import pcxrle_pkg::*;

    logic               r_expect, n_expect;
    logic [COUNT_W-1:0] r_pending, n_pending;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic               r_done, n_done;

    logic [COL_W-1:0]   w;
    logic [ROW_W-1:0]   h;
    logic [COL_W-1:0]   col0;
    logic [ROW_W-1:0]   row0;
    logic [ROW_W-1:0]   row_inc;
    logic [COL_W-1:0]   avail;
    logic [COUNT_W-1:0] run_n;
    logic               closed;
    logic               emit;
    logic               reach;

    always_comb begin
        if (i_width == '0) begin
            w = COL_W'(1);
        end else if (i_width > MAX_WIDTH) begin
            w = MAX_WIDTH;
        end else begin
            w = i_width;
        end
        if (i_height == '0) begin
            h = ROW_W'(1);
        end else if (i_height > MAX_HEIGHT) begin
            h = MAX_HEIGHT;
        end else begin
            h = i_height;
        end
    end

    always_comb begin
        n_expect   = r_expect;
        n_pending  = r_pending;
        n_col      = r_col;
        n_row      = r_row;
        n_done     = r_done;
        col0       = r_col;
        row0       = r_row;
        row_inc    = r_row + ROW_W'(1);
        closed     = 1'b0;
        emit       = 1'b0;
        run_n      = '0;
        avail      = w - r_col;
        reach      = 1'b0;
        o_cmd_push = 1'b0;

        if (i_accept && !r_done) begin
            if (r_row >= h) begin
                n_done = 1'b1;
            end else begin
                // A width lowered below the current column closes the row first.
                if (r_col >= w) begin
                    col0  = '0;
                    row0  = row_inc;
                    n_col = '0;
                    n_row = row_inc;
                    if (row_inc >= h) begin
                        n_done = 1'b1;
                        closed = 1'b1;
                    end
                end
                if (!closed) begin
                    if (r_expect) begin
                        n_expect  = 1'b0;
                        n_pending = '0;
                        run_n     = r_pending;
                        emit      = 1'b1;
                    end else if ((i_code_byte & RUN_MARK) == RUN_MARK) begin
                        n_expect  = 1'b1;
                        n_pending = i_code_byte[COUNT_W-1:0];
                    end else begin
                        run_n = COUNT_W'(1);
                        emit  = 1'b1;
                    end
                    avail   = w - col0;
                    row_inc = row0 + ROW_W'(1);
                    if (emit) begin
                        reach = {{(COL_W-COUNT_W){1'b0}}, run_n} >= avail;
                        if (reach) begin
                            n_col = '0;
                            n_row = row_inc;
                            if (row_inc >= h) begin
                                n_done = 1'b1;
                            end
                        end else begin
                            n_col = col0 + {{(COL_W-COUNT_W){1'b0}}, run_n};
                        end
                        o_cmd_push = (run_n != '0);
                    end
                end
            end
        end
    end

    // When the run reaches the row end its count is the room left, which is
    // then no more than the run length.
    always_comb begin
        o_cmd.value   = i_code_byte;
        o_cmd.col     = col0;
        o_cmd.row     = row0;
        o_cmd.count   = reach ? avail[COUNT_W-1:0] : run_n;
        o_cmd.img_end = reach && (row0 == h - ROW_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect  <= 1'b0;
            r_pending <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_done    <= 1'b0;
        end else begin
            r_expect  <= n_expect;
            r_pending <= n_pending;
            r_col     <= n_col;
            r_row     <= n_row;
            r_done    <= n_done;
        end
    end

endmodule

`default_nettype wire

/* src/pcxrle_queue.sv */
// ----------------------------------------------------------------------------
// pcxrle_queue
// Short first-in first-out queue of run commands between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcxrle_queue #(
    parameter int P_DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  pcxrle_pkg::t_cmd       i_cmd,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output pcxrle_pkg::t_cmd       o_cmd
);
    import pcxrle_pkg::*;

    localparam int PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(P_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(P_DEPTH);

    t_cmd          r_mem [P_DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == LAST_PTR) ? '0 : r_wp + PW'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == LAST_PTR) ? '0 : r_rp + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

/* src/pcxrle_back.sv */
// ----------------------------------------------------------------------------
// pcxrle_back
// Expands run commands into single pixels, one per cycle while the consumer
// keeps up, into an output register that the consumer drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcxrle_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cmd_empty,
    input  pcxrle_pkg::t_cmd                   i_cmd,
    output logic                               o_cmd_pop,
    output logic                               o_empty,
    input  wire logic                          i_pop,
    output logic [7:0]                         o_pixel_value,
    output logic [pcxrle_pkg::COL_W-1:0]       o_pixel_column,
    output logic [pcxrle_pkg::ROW_W-1:0]       o_pixel_row,
    output logic                               o_run_last,
    output logic                               o_image_last
);
    import pcxrle_pkg::*;

    logic               r_busy;
    logic [7:0]         r_value;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [COUNT_W-1:0] r_rem;
    logic               r_img_end;

    logic               r_ov;
    logic [7:0]         r_o_value;
    logic [COL_W-1:0]   r_o_col;
    logic [ROW_W-1:0]   r_o_row;
    logic               r_o_run_last;
    logic               r_o_img_last;

    logic               slot_free;
    logic               emit;
    logic               last;

    assign slot_free = !r_ov || i_pop;
    assign emit      = r_busy && slot_free;
    assign last      = (r_rem == COUNT_W'(1));
    // The next run is loaded in the cycle the current one gives its last beat.
    assign o_cmd_pop = !i_cmd_empty && (!r_busy || (emit && last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_busy <= 1'b1;
            end else if (emit && last) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_value   <= i_cmd.value;
            r_col     <= i_cmd.col;
            r_row     <= i_cmd.row;
            r_rem     <= i_cmd.count;
            r_img_end <= i_cmd.img_end;
        end else if (emit) begin
            r_col <= r_col + COL_W'(1);
            r_rem <= r_rem - COUNT_W'(1);
        end
        if (emit) begin
            r_o_value    <= r_value;
            r_o_col      <= r_col;
            r_o_row      <= r_row;
            r_o_run_last <= last;
            r_o_img_last <= last && r_img_end;
        end
    end

    assign o_empty        = !r_ov;
    assign o_pixel_value  = r_o_value;
    assign o_pixel_column = r_o_col;
    assign o_pixel_row    = r_o_row;
    assign o_run_last     = r_o_run_last;
    assign o_image_last   = r_o_img_last;

endmodule

`default_nettype wire

/* src/pcx_rle_pixel_decoder.sv */
// ----------------------------------------------------------------------------
// pcx_rle_pixel_decoder
// Decodes the run-length pixel stream of an 8-bit PCX image into pixels
// tagged with column, row and end-of-run / end-of-image flags.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Payload
//  ------    ---------          -------
//  input     push / full        i_code_byte
//  result    empty / pop        o_pixel_value, o_pixel_column, o_pixel_row,
//                               o_run_last, o_image_last
//  config    i_cfg_we           i_cfg_index, i_cfg_data
//
// The front takes one byte per cycle while the command queue has room.
// The back gives one pixel beat per cycle while its output register is
// empty or being popped. A byte's first pixel passes through the queue,
// the back's run registers and then the output register.
// Synchronous reset restores width 320 and height 200 and starts a new image.
// A stalled result side fills the queue and then holds full high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcx_rle_pixel_decoder #(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [7:0]                    i_code_byte,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [7:0]                         o_pixel_value,
    output logic [pcxrle_pkg::COL_W-1:0]       o_pixel_column,
    output logic [pcxrle_pkg::ROW_W-1:0]       o_pixel_row,
    output logic                               o_run_last,
    output logic                               o_image_last,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_index,
    input  wire logic [pcxrle_pkg::CFG_W-1:0]  i_cfg_data
);
    import pcxrle_pkg::*;

    logic [COL_W-1:0] r_width;
    logic [ROW_W-1:0] r_height;

    logic             accept;
    logic             cmd_push;
    t_cmd             cmd_in;
    t_cmd             cmd_out;
    logic             cmd_empty;
    logic             cmd_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH:  r_width  <= i_cfg_data[COL_W-1:0];
                REG_HEIGHT: r_height <= i_cfg_data[ROW_W-1:0];
                default:    r_width  <= r_width;
            endcase
        end
    end

    assign accept = push && !full;

    pcxrle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_code_byte (i_code_byte),
        .i_width     (r_width),
        .i_height    (r_height),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in)
    );

    pcxrle_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_cmd   (cmd_out)
    );

    pcxrle_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_empty    (cmd_empty),
        .i_cmd          (cmd_out),
        .o_cmd_pop      (cmd_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_pixel_value  (o_pixel_value),
        .o_pixel_column (o_pixel_column),
        .o_pixel_row    (o_pixel_row),
        .o_run_last     (o_run_last),
        .o_image_last   (o_image_last)
    );

endmodule

`default_nettype wire

/* bench/pcx_rle_pixel_decoder_tb.sv */
// ----------------------------------------------------------------------------
// pcx_rle_pixel_decoder_tb
// Self-checking bench for the PCX run-length pixel decoder. A driver pushes
// code bytes from a queue and predicts the pixels of each accepted byte, and a
// monitor pops pixel beats and compares them field by field. The run walks
// through several image sizes, with and without idling on either side, and
// ends by completing an image and feeding bytes that must be ignored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcx_rle_pixel_decoder_tb;

    import pcxrle_pkg::*;

    typedef struct packed {
        logic [7:0] code;
        logic       drain_first;
    } t_code_item;

    typedef struct packed {
        logic [7:0]       value;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             run_last;
        logic             image_last;
    } t_pixel;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    logic [7:0]       i_code_byte = 8'h00;
    logic             empty;
    logic             pop = 1'b0;
    logic [7:0]       o_pixel_value;
    logic [COL_W-1:0] o_pixel_column;
    logic [ROW_W-1:0] o_pixel_row;
    logic             o_run_last;
    logic             o_image_last;
    logic             i_cfg_we = 1'b0;
    logic             i_cfg_index = REG_WIDTH;
    logic [CFG_W-1:0] i_cfg_data = '0;

    t_code_item code_bytes[$];
    t_pixel     pending_pixels[$];
    int         fail_count = 0;
    int         sender_idle_pct = 27;
    int         receiver_idle_pct = 64;

    // Decoder state as the bench sees it.
    logic [COL_W-1:0]   img_width = RESET_WIDTH;
    logic [ROW_W-1:0]   img_height = RESET_HEIGHT;
    logic               awaiting_value = 1'b0;
    logic [COUNT_W-1:0] run_length = '0;
    logic [COL_W-1:0]   cur_col = '0;
    logic [ROW_W-1:0]   cur_row = '0;
    logic               image_done = 1'b0;

    pcx_rle_pixel_decoder uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_code_byte    (i_code_byte),
        .empty          (empty),
        .pop            (pop),
        .o_pixel_value  (o_pixel_value),
        .o_pixel_column (o_pixel_column),
        .o_pixel_row    (o_pixel_row),
        .o_run_last     (o_run_last),
        .o_image_last   (o_image_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    task automatic advance_row(input int unsigned h);
        cur_col = '0;
        cur_row = cur_row + 1'b1;
        if (cur_row >= h) begin
            image_done = 1'b1;
        end
    endtask

    // Appends the pixels that one accepted code byte yields.
    task automatic decode_code_byte(input logic [7:0] code);
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned made;
        t_pixel      px;
        w = (img_width == 0) ? 1 : (img_width > MAX_WIDTH) ? MAX_WIDTH : img_width;
        h = (img_height == 0) ? 1 : (img_height > MAX_HEIGHT) ? MAX_HEIGHT : img_height;
        made = 0;
        if (image_done) begin
            return;
        end
        if (cur_row >= h) begin
            image_done = 1'b1;
            return;
        end
        // A width lowered under the current column closes the row first.
        if (cur_col >= w) begin
            advance_row(h);
            if (image_done) begin
                return;
            end
        end
        if (awaiting_value) begin
            awaiting_value = 1'b0;
            n = run_length;
            run_length = '0;
        end else if ((code & RUN_MARK) == RUN_MARK) begin
            awaiting_value = 1'b1;
            run_length = code[COUNT_W-1:0];
            return;
        end else begin
            n = 1;
        end
        // Pixels past the row end are dropped.
        while (made < n && cur_col < w) begin
            px.value      = code;
            px.col        = cur_col;
            px.row        = cur_row;
            px.run_last   = (made + 1 == n) || (cur_col + 1 == w);
            px.image_last = (cur_col == w - 1) && (cur_row == h - 1);
            pending_pixels.push_back(px);
            cur_col = cur_col + 1'b1;
            made++;
        end
        if (cur_col >= w) begin
            advance_row(h);
        end
    endtask

    task automatic check_pixel();
        t_pixel want;
        if (pending_pixels.size() == 0) begin
            $error("pixel beat with nothing expected: value %0d column %0d row %0d",
                   o_pixel_value, o_pixel_column, o_pixel_row);
            fail_count++;
        end else begin
            want = pending_pixels.pop_front();
            if (o_pixel_value !== want.value) begin
                $error("pixel_value expected %0d got %0d", want.value, o_pixel_value);
                fail_count++;
            end
            if (o_pixel_column !== want.col) begin
                $error("pixel_column expected %0d got %0d", want.col, o_pixel_column);
                fail_count++;
            end
            if (o_pixel_row !== want.row) begin
                $error("pixel_row expected %0d got %0d", want.row, o_pixel_row);
                fail_count++;
            end
            if (o_run_last !== want.run_last) begin
                $error("run_last expected %0d got %0d", want.run_last, o_run_last);
                fail_count++;
            end
            if (o_image_last !== want.image_last) begin
                $error("image_last expected %0d got %0d", want.image_last, o_image_last);
                fail_count++;
            end
        end
    endtask

    // Driver: the beat on the bus is always the head of the code byte queue.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                decode_code_byte(i_code_byte);
                code_bytes.delete(0);
            end
            if (code_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct
                    && !(code_bytes[0].drain_first && pending_pixels.size() != 0)) begin
                push <= 1'b1;
                i_code_byte <= code_bytes[0].code;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                check_pixel();
            end
            pop <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Now and then the sender holds a byte until every pixel has come out.
    task automatic queue_code(input logic [7:0] code);
        t_code_item item;
        item.code        = code;
        item.drain_first = ($urandom_range(99) < 5);
        code_bytes.push_back(item);
    endtask

    task automatic add_random_bytes(input int count);
        int added;
        int roll;
        added = 0;
        while (added < count) begin
            roll = $urandom_range(99);
            if (roll < 45) begin
                queue_code(8'($urandom_range(8'hBF)));
                added++;
            end else if (roll < 85) begin
                if ($urandom_range(1) == 1) begin
                    queue_code({2'b11, 6'($urandom_range(7))});
                end else begin
                    queue_code({2'b11, 6'($urandom_range(63))});
                end
                queue_code(8'($urandom_range(255)));
                added += 2;
            end else begin
                // Stray byte: may be a header that swallows the next header.
                queue_code(8'($urandom_range(255)));
                added++;
            end
        end
    endtask

    // Registers are only written once the decoder has gone quiet.
    task automatic wait_until_idle();
        while (code_bytes.size() != 0 || push || pending_pixels.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (10) @(negedge i_clk);
    endtask

    task automatic set_register(input logic index, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        if (index == REG_WIDTH) begin
            img_width = data;
        end else begin
            img_height = data[ROW_W-1:0];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int phase;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset size: literals of every kind, a zero-length run, a run of one,
        // a full 63-pixel run and a run whose value looks like a header.
        queue_code(8'h00); queue_code(8'hBF); queue_code(8'h7F); queue_code(8'h80);
        queue_code(8'hC0); queue_code(8'hAA);
        queue_code(8'hC1); queue_code(8'hFF);
        queue_code(8'hFF); queue_code(8'h55);
        queue_code(8'hC3); queue_code(8'hC3);
        queue_code(8'h01); queue_code(8'h3F);
        queue_code(8'hC2); queue_code(8'h00);

        // Oversized width and zero height, kept short of the row end.
        wait_until_idle();
        set_register(REG_WIDTH, 10'd1023);
        set_register(REG_HEIGHT, 10'd0);
        @(negedge i_clk);
        queue_code(8'h12); queue_code(8'hC4); queue_code(8'h9E); queue_code(8'hA5);

        // Width lowered under the current column, then a run past the row end.
        wait_until_idle();
        set_register(REG_WIDTH, 10'd2);
        set_register(REG_HEIGHT, 10'd511);
        @(negedge i_clk);
        queue_code(8'hC5); queue_code(8'h77); queue_code(8'h44);

        for (phase = 0; phase < 6; phase++) begin
            wait_until_idle();
            case (phase)
                0: begin
                    set_register(REG_WIDTH, 10'd640);
                    set_register(REG_HEIGHT, 10'd480);
                end
                1: set_register(REG_WIDTH, 10'd0);
                2: set_register(REG_WIDTH, 10'd1);
                3: set_register(REG_WIDTH, 10'($urandom_range(24, 2)));
                4: set_register(REG_WIDTH, 10'($urandom_range(640, 1)));
                default: begin
                    set_register(REG_WIDTH, 10'd1023);
                    set_register(REG_HEIGHT, 10'd511);
                end
            endcase
            @(negedge i_clk);
            sender_idle_pct   = (phase < 2) ? 27 : (phase < 4) ? 64 : 0;
            receiver_idle_pct = (phase < 2) ? 64 : (phase < 4) ? 27 : 0;
            add_random_bytes(12);
        end

        // Finish the image two rows on, then bytes that must be ignored.
        wait_until_idle();
        set_register(REG_WIDTH, 10'd3);
        set_register(REG_HEIGHT, {1'b0, cur_row + 9'd2});
        @(negedge i_clk);
        repeat (10) queue_code(8'($urandom_range(8'hBF)));
        queue_code(8'hC5); queue_code(8'h21); queue_code(8'hFF); queue_code(8'h00);
        queue_code(8'h80); queue_code(8'h7E);

        wait_until_idle();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
